// ===== rtl/core/xbsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbsp_pkg: shared types and constants of the block-seeded xoshiro generator
// Holds the generator constants, the datapath operation codes and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package xbsp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 53;
  localparam int unsigned HalfW = 32;

  localparam logic [WordW-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [WordW-1:0] BLOCK_OFFSET = 64'hD1B5_4A32_D192_ED03;

  // Partial-product steps of the 64 x 64 (low half) multiply.
  typedef logic [1:0] mul_step_t;
  localparam mul_step_t MUL_LL = 2'd0;  // a_lo * b_lo
  localparam mul_step_t MUL_HL = 2'd1;  // a_hi * b_lo, shifted up 32
  localparam mul_step_t MUL_LH = 2'd2;  // a_lo * b_hi, shifted up 32

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DRAW,     // advance the generator and load the output register
    OP_START,    // load block index and gamma as multiply operands
    OP_MUL,      // one partial product into the accumulator
    OP_MIX,      // splitmix state from the seed and the block product
    OP_ADVANCE,  // step the splitmix state, load first mix operands
    OP_SECOND,   // load second mix operands from the product
    OP_STORE     // finish one splitmix output into a generator word
  } op_t;

  typedef struct packed {
    op_t       op;
    mul_step_t mul_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or being taken this cycle
    logic last_word;  // the next store fills the final generator word
  } status_t;

endpackage

// ===== rtl/core/xbsp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbsp_in_if: request channel into the generator
// Carries the function select and the stream number of one request.
// ----------------------------------------------------------------------------
interface xbsp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] stream_id;

  modport source (output valid, output func, output stream_id, input ready);
  modport sink   (input valid, input func, input stream_id, output ready);
endinterface

// ===== rtl/core/xbsp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbsp_out_if: result channel out of the generator
// Carries the raw output word and the 53-bit uniform numerator.
// ----------------------------------------------------------------------------
interface xbsp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_bits;
  logic [52:0] uniform_fraction;

  modport source (output valid, output random_bits, output uniform_fraction,
                  input ready);
  modport sink   (input valid, input random_bits, input uniform_fraction,
                  output ready);
endinterface

// ===== rtl/core/xbsp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbsp_cfg_if: configuration write channel
// Carries the write data of the run seed register.
// ----------------------------------------------------------------------------
interface xbsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/xbsp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbsp_datapath: generator words, splitmix seeding and output register
// Executes one operation per cycle as commanded by the controller, with one
// shared 32 x 32 multiplier for the seeding multiplies.
// ----------------------------------------------------------------------------
module xbsp_datapath
  import xbsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          sts,
  input  logic [WordW-1:0] stream_id,
  input  logic             cfg_we,
  input  logic [WordW-1:0] cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [WordW-1:0] random_bits,
  output logic [FracW-1:0] uniform_fraction
);

  logic [WordW-1:0] base_seed;
  logic [WordW-1:0] gen_words [4];
  logic [WordW-1:0] mixer_state;
  logic [2:0]       seed_word_count;
  logic [WordW-1:0] opa;
  logic [WordW-1:0] opb;
  logic [WordW-1:0] acc;

  logic [HalfW-1:0] mul_x;
  logic [HalfW-1:0] mul_y;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] mixer_adv;
  logic [WordW-1:0] sum0;
  logic [WordW-1:0] draw_res;
  logic [WordW-1:0] n0, n1, n2, n3;
  logic [FracW-1:0] frac;

  // Shared multiplier: pick the operand halves for this partial product.
  always_comb begin
    mul_x = opa[HalfW-1:0];
    mul_y = opb[HalfW-1:0];
    case (cmd.mul_step)
      MUL_HL:  mul_x = opa[WordW-1:HalfW];
      MUL_LH:  mul_y = opb[WordW-1:HalfW];
      default: ;
    endcase
    prod = mul_x * mul_y;
  end

  assign mixer_adv = mixer_state + GOLDEN_GAMMA;

  // xoshiro256++ output and state update.
  always_comb begin
    sum0     = gen_words[0] + gen_words[3];
    draw_res = {sum0[40:0], sum0[63:41]} + gen_words[0];
    n2 = gen_words[2] ^ gen_words[0];
    n3 = gen_words[3] ^ gen_words[1];
    n1 = gen_words[1] ^ n2;
    n0 = gen_words[0] ^ n3;
    frac = draw_res[WordW-1:WordW-FracW];
    if (frac == '0) begin
      frac = FracW'(1);
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.last_word = (seed_word_count == 3'd3);

  // Control registers and generator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seed       <= '0;
      gen_words[0]    <= '0;
      gen_words[1]    <= '0;
      gen_words[2]    <= '0;
      gen_words[3]    <= '0;
      mixer_state     <= '0;
      seed_word_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_seed <= cfg_data;
      end
      // A new draw loads the output register; otherwise a taken result empties it.
      if (cmd.op == OP_DRAW) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_DRAW: begin
          gen_words[0] <= n0;
          gen_words[1] <= n1;
          gen_words[2] <= n2 ^ (gen_words[1] << 17);
          gen_words[3] <= {n3[18:0], n3[63:19]};
        end
        OP_START: begin
          seed_word_count <= '0;
        end
        OP_MIX: begin
          mixer_state <= base_seed ^ (acc + BLOCK_OFFSET);
        end
        OP_ADVANCE: begin
          mixer_state <= mixer_adv;
        end
        OP_STORE: begin
          gen_words[seed_word_count[1:0]] <= acc ^ (acc >> 31);
          seed_word_count <= seed_word_count + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers: multiply operands, accumulator and output.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_DRAW: begin
        random_bits      <= draw_res;
        uniform_fraction <= frac;
      end
      OP_START: begin
        opa <= stream_id;
        opb <= GOLDEN_GAMMA;
      end
      OP_MUL: begin
        if (cmd.mul_step == MUL_LL) begin
          acc <= prod;
        end else begin
          acc <= acc + {prod[HalfW-1:0], {HalfW{1'b0}}};
        end
      end
      OP_ADVANCE: begin
        opa <= mixer_adv ^ (mixer_adv >> 30);
        opb <= MIX_MUL_A;
      end
      OP_SECOND: begin
        opa <= acc ^ (acc >> 27);
        opb <= MIX_MUL_B;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/xbsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xbsp_ctrl: sequencing state machine of the generator
// Accepts requests, issues a draw in the accept cycle, and steps a restart
// through the seed multiply and four splitmix rounds.
// ----------------------------------------------------------------------------
module xbsp_ctrl
  import xbsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_func,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED_MUL = 3'd1;
  localparam logic [2:0] ST_MIX      = 3'd2;
  localparam logic [2:0] ST_ADV      = 3'd3;
  localparam logic [2:0] ST_MUL_A    = 3'd4;
  localparam logic [2:0] ST_SECOND   = 3'd5;
  localparam logic [2:0] ST_MUL_B    = 3'd6;
  localparam logic [2:0] ST_STORE    = 3'd7;

  logic [2:0] state, state_next;
  mul_step_t  step, step_next;
  logic       mul_done;

  assign mul_done = (step == MUL_LH);

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd.op       = OP_NOP;
    cmd.mul_step = step;
    in_ready     = (state == ST_IDLE) && sts.out_free;
    unique case (state) inside
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_func) begin
            cmd.op     = OP_START;
            state_next = ST_SEED_MUL;
            step_next  = MUL_LL;
          end else begin
            cmd.op = OP_DRAW;
          end
        end
      end
      ST_SEED_MUL, ST_MUL_A, ST_MUL_B: begin
        cmd.op = OP_MUL;
        if (mul_done) begin
          step_next = MUL_LL;
          if (state == ST_SEED_MUL) begin
            state_next = ST_MIX;
          end else if (state == ST_MUL_A) begin
            state_next = ST_SECOND;
          end else begin
            state_next = ST_STORE;
          end
        end else begin
          step_next = step + 2'd1;
        end
      end
      ST_MIX: begin
        cmd.op     = OP_MIX;
        state_next = ST_ADV;
      end
      ST_ADV: begin
        cmd.op     = OP_ADVANCE;
        state_next = ST_MUL_A;
      end
      ST_SECOND: begin
        cmd.op     = OP_SECOND;
        state_next = ST_MUL_B;
      end
      ST_STORE: begin
        cmd.op     = OP_STORE;
        state_next = sts.last_word ? ST_IDLE : ST_ADV;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= MUL_LL;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== rtl/core/xoshiro_block_seeded_prng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro_block_seeded_prng: xoshiro256++ generator with per-block seeding
// Usage:
//   din carries requests. func 0 draws one value; func 1 restarts the stream
//   for stream_id, seeding the four words by splitmix64 from base_seed XOR
//   (stream_id * golden gamma + offset). A restart gives no result.
//   dout carries one result per draw: random_bits and uniform_fraction (top
//   53 bits of the output, zero mapped to one).
//   cfg writes base_seed; it is always ready and should be written only
//   while no request is in flight.
// Timing:
//   A draw is computed in its accept cycle and shows on dout in the cycle
//   after; with dout drained, a draw is accepted every cycle.
//   A restart occupies the block through nine 64-bit multiplies, each
//   three passes through the shared 32 x 32 multiplier, plus the mixing and
//   store steps. din is not ready during that time.
// Reset: the generator words, splitmix state and base_seed go to zero, so a
//   draw before any restart returns 0 with uniform_fraction 1.
// Stall: while a result waits on dout, din is ready only in the cycle in
//   which dout is taken.
// ----------------------------------------------------------------------------
module xoshiro_block_seeded_prng
  import xbsp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  xbsp_in_if.sink     din,
  xbsp_out_if.source  dout,
  xbsp_cfg_if.sink    cfg
);

  cmd_t    cmd;
  status_t sts;

  // Seed register writes are taken at once.
  assign cfg.ready = 1'b1;

  xbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_func  (din.func),
    .in_ready (din.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xbsp_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .stream_id        (din.stream_id),
    .cfg_we           (cfg.valid),
    .cfg_data         (cfg.data),
    .out_ready        (dout.ready),
    .out_valid        (dout.valid),
    .random_bits      (dout.random_bits),
    .uniform_fraction (dout.uniform_fraction)
  );

endmodule

// ===== tb/tb_xoshiro_block_seeded_prng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xoshiro_block_seeded_prng: self-checking bench of the seeded generator
// Drives draw and restart requests through the request channel and writes the
// run seed through the configuration channel. A local xoshiro256++ and
// splitmix64 predictor computes every draw, and each result is compared field
// by field in order. Sender bursts and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_xoshiro_block_seeded_prng
  import xbsp_pkg::*;
();

  localparam logic FUNC_DRAW    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam int unsigned SETTLE_CYCLES = 48;      // outlasts the time a restart keeps the block busy
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  typedef struct packed {
    logic [WordW-1:0] random_bits;
    logic [FracW-1:0] uniform_fraction;
  } draw_result_t;

  logic clk;
  logic rst;

  xbsp_in_if  din_if ();
  xbsp_out_if dout_if ();
  xbsp_cfg_if cfg_if ();

  xoshiro_block_seeded_prng i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  // Predictor state: run seed, splitmix counter and the four generator words.
  logic [WordW-1:0] run_seed;
  logic [WordW-1:0] mix_counter;
  logic [WordW-1:0] stream_word [4];

  draw_result_t expected_draws [$];

  int unsigned cycle_count = 0;
  int unsigned n_fail;
  int unsigned n_draws;
  int unsigned n_restarts;
  int unsigned n_seed_writes;
  int unsigned n_checked;

  // Idling controls, changed by the test tasks.
  int unsigned gap_max;
  int unsigned burst_left;
  int unsigned stall_pct;
  int unsigned stall_max;
  int unsigned stall_left = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] v, input int unsigned s);
    return (v << s) | (v >> (WordW - s));
  endfunction

  // One splitmix64 output; advances the shared counter.
  function automatic logic [WordW-1:0] splitmix_next();
    logic [WordW-1:0] z;
    mix_counter = mix_counter + GOLDEN_GAMMA;
    z = mix_counter;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // Applies one accepted request to the predictor and queues its draw.
  function automatic void predict_request(input logic f, input logic [WordW-1:0] blk);
    logic [WordW-1:0] bits;
    logic [WordW-1:0] shifted;
    logic [WordW-1:0] frac;
    draw_result_t     res;
    if (f == FUNC_RESTART) begin
      mix_counter = run_seed ^ (blk * GOLDEN_GAMMA + BLOCK_OFFSET);
      for (int i = 0; i < 4; i++) stream_word[i] = splitmix_next();
      return;
    end
    bits = rotl64(stream_word[0] + stream_word[3], 23) + stream_word[0];
    shifted = stream_word[1] << 17;
    stream_word[2] = stream_word[2] ^ stream_word[0];
    stream_word[3] = stream_word[3] ^ stream_word[1];
    stream_word[1] = stream_word[1] ^ stream_word[2];
    stream_word[0] = stream_word[0] ^ stream_word[3];
    stream_word[2] = stream_word[2] ^ shifted;
    stream_word[3] = rotl64(stream_word[3], 45);
    frac = bits >> 11;
    if (frac == '0) frac = WordW'(1);
    res.random_bits      = bits;
    res.uniform_fraction = frac[FracW-1:0];
    expected_draws.push_back(res);
  endfunction

  // Receiver: held off during reset, then ready most of the time with
  // stalls of random length.
  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      dout_if.ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(stall_max);
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    draw_result_t exp_res;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected result: random_bits %h uniform_fraction %h",
               dout_if.random_bits, dout_if.uniform_fraction);
        n_fail++;
      end else begin
        exp_res = expected_draws.pop_front();
        n_checked++;
        if (dout_if.random_bits !== exp_res.random_bits) begin
          $error("random_bits: expected %h, got %h", exp_res.random_bits, dout_if.random_bits);
          n_fail++;
        end
        if (dout_if.uniform_fraction !== exp_res.uniform_fraction) begin
          $error("uniform_fraction: expected %h, got %h",
                 exp_res.uniform_fraction, dout_if.uniform_fraction);
          n_fail++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sends one request, opening a new burst after a random gap when due.
  task automatic send_request(input logic f, input logic [WordW-1:0] blk);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap != 0) begin
        din_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    din_if.valid     <= 1'b1;
    din_if.func      <= f;
    din_if.stream_id <= blk;
    do @(posedge clk); while (!din_if.ready);
    predict_request(f, blk);
    if (f == FUNC_RESTART) n_restarts++;
    else n_draws++;
  endtask

  // Holds the sender until every expected result has come, then lets a
  // restart still in progress run out.
  task automatic wait_drained(input int unsigned settle);
    din_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes the run seed; only called with the block idle.
  task automatic write_seed(input logic [WordW-1:0] seed);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= seed;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    run_seed = seed;
    n_seed_writes++;
  endtask

  function automatic logic [WordW-1:0] pick_block_index();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return WordW'($urandom_range(15));
    if (sel < 35) return ~WordW'($urandom_range(15));
    return {$urandom(), $urandom()};
  endfunction

  // Draws straight out of reset run on all-zero words, whatever the index.
  task automatic test_unseeded_draws();
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_DRAW, '1);
    send_request(FUNC_DRAW, {$urandom(), $urandom()});
    send_request(FUNC_DRAW, 64'h5555_5555_5555_5555);
    wait_drained(0);
  endtask

  // Seed and block index at their extremes, back-to-back restarts.
  task automatic test_seed_extremes();
    send_request(FUNC_RESTART, '0);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_DRAW, '1);
    send_request(FUNC_RESTART, '1);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_RESTART, 64'd1);
    send_request(FUNC_RESTART, 64'h8000_0000_0000_0000);
    send_request(FUNC_DRAW, '1);
    wait_drained(SETTLE_CYCLES);
    write_seed('1);
    send_request(FUNC_RESTART, '0);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_RESTART, '1);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_DRAW, '0);
    send_request(FUNC_RESTART, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(FUNC_DRAW, '0);
    wait_drained(SETTLE_CYCLES);
    write_seed(64'h8000_0000_0000_0001);
    send_request(FUNC_RESTART, 64'd2);
    send_request(FUNC_DRAW, '0);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Random streams: mostly a restart then a run of draws, plus stray requests.
  task automatic test_random_streams();
    int unsigned left;
    int unsigned run_len;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          gap_max = 0; stall_pct = 0; stall_max = 0;
        end
        1: begin
          gap_max = 3; stall_pct = 30; stall_max = 3;
        end
        2: begin
          gap_max = 8; stall_pct = 60; stall_max = 12;
        end
        3: begin
          gap_max = 1; stall_pct = 10; stall_max = 1;
        end
        default: begin
          gap_max = $urandom_range(6); stall_pct = $urandom_range(50); stall_max = 6;
        end
      endcase
      write_seed(phase == 3 ? '0 : {$urandom(), $urandom()});
      left = 100;
      while (left != 0) begin
        if ($urandom_range(99) < 80) begin
          send_request(FUNC_RESTART, pick_block_index());
          run_len = $urandom_range(20, 1);
          if (run_len > left - 1) run_len = left - 1;
          for (int i = 0; i < run_len; i++) send_request(FUNC_DRAW, {$urandom(), $urandom()});
          left = left - 1 - run_len;
        end else begin
          send_request($urandom_range(1) ? FUNC_RESTART : FUNC_DRAW, pick_block_index());
          left--;
        end
        // Around the halfway point, the sender at random holds off until all results are back.
        if (left <= 50 && left + 21 > 50 && $urandom_range(3) == 0) wait_drained(0);
      end
      wait_drained(SETTLE_CYCLES);
    end
  endtask

  initial begin
    rst <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.func <= FUNC_DRAW;
    din_if.stream_id <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    run_seed = '0;
    mix_counter = '0;
    for (int i = 0; i < 4; i++) stream_word[i] = '0;
    n_fail = 0;
    n_draws = 0;
    n_restarts = 0;
    n_seed_writes = 0;
    n_checked = 0;
    gap_max = 0;
    burst_left = 0;
    stall_pct = 0;
    stall_max = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_unseeded_draws();
    gap_max = 2;
    stall_pct = 25;
    stall_max = 4;
    test_seed_extremes();
    test_random_streams();
    wait_drained(SETTLE_CYCLES);

    $display("Run covered %0d draws and %0d stream restarts over %0d run seed writes.",
             n_draws, n_restarts, n_seed_writes);
    $display("%0d results compared, %0d field mismatches or stray results.", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
